/* sv/crc8_frame_receiver_macros.svh */
// Assertion macros used by the frame receiver queue module.
// Expects signals named clock and reset in the module that uses them.
`ifndef CRC8_FRAME_RECEIVER_MACROS_SVH
`define CRC8_FRAME_RECEIVER_MACROS_SVH

// Condition must hold at every clock edge outside reset.
`define C8FR_ASSERT_ALWAYS(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// When the trigger holds, the outcome must hold in the next cycle.
`define C8FR_ASSERT_NEXT(lbl, trig, outcome, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (trig) |=> (outcome)) \
      else $error(msg);

`endif

/* sv/c8fr_pkg.sv */
// Shared types, codes and the CRC-8 byte step for the frame receiver.
// No dependencies; the modules and the testbench refer to it by scoped names.
package c8fr_pkg;

   localparam logic [7:0] SYNC_FIRST_RESET  = 8'hAA;
   localparam logic [7:0] SYNC_SECOND_RESET = 8'h55;
   localparam logic [7:0] CRC_INIT          = 8'hFF;
   localparam logic [7:0] CRC_POLY_REFL     = 8'h8C;

   localparam int unsigned CSR_INDEX_W = 1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SYNC_FIRST  = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SYNC_SECOND = 1'b1;

   localparam logic [1:0] OP_FUNC = 2'd0;
   localparam logic [1:0] OP_LEN  = 2'd1;
   localparam logic [1:0] OP_DATA = 2'd2;
   localparam logic [1:0] OP_CRC  = 2'd3;

   localparam logic [1:0] KIND_PAYLOAD  = 2'd0;
   localparam logic [1:0] KIND_GOOD     = 2'd1;
   localparam logic [1:0] KIND_MISMATCH = 2'd2;

   typedef struct packed {
      logic [1:0] op_code;
      logic [7:0] data;
      logic [7:0] position;
   } op_type;

   function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
      logic [7:0] c;
      c = crc ^ b;
      for (int i = 0; i < 8; i++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY_REFL;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

/* sv/c8fr_req_if.sv */
// Input channel of the frame receiver: one received byte per transaction.
// No dependencies.
interface c8fr_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

/* sv/c8fr_rsp_if.sv */
// Result channel of the frame receiver: payload bytes and frame verdicts.
// No dependencies.
interface c8fr_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] kind;
   logic [7:0] func_code;
   logic [7:0] value;
   logic [7:0] position;
   logic       frame_end;

   modport source (output valid, output kind, output func_code, output value,
                   output position, output frame_end, input ready);
   modport sink (input valid, input kind, input func_code, input value,
                 input position, input frame_end, output ready);
endinterface

/* sv/c8fr_front.sv */
// Front end: sync hunting, header parsing and classification of each byte.
// Depends on c8fr_pkg and c8fr_req_if.
module c8fr_front (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_we,
   input  logic [c8fr_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [7:0]                       csr_wdata,
   c8fr_req_if.sink                         req_if,
   input  logic                             q_full,
   output logic                             push,
   output c8fr_pkg::op_type                 push_op
);

   localparam logic [2:0] PH_HUNT  = 3'd0;
   localparam logic [2:0] PH_SYNC2 = 3'd1;
   localparam logic [2:0] PH_FUNC  = 3'd2;
   localparam logic [2:0] PH_LEN   = 3'd3;
   localparam logic [2:0] PH_DATA  = 3'd4;
   localparam logic [2:0] PH_CRC   = 3'd5;

   logic [7:0] sync_first_ff, sync_second_ff;
   logic [2:0] phase_ff, phase_in;
   logic [7:0] length_ff, length_in;
   logic [7:0] count_ff, count_in;
   logic [7:0] count_next;
   logic       fire;
   logic [7:0] b;

   assign req_if.ready = !q_full;
   assign fire         = req_if.valid && !q_full;
   assign b            = req_if.rx_byte;
   assign count_next   = count_ff + 8'd1;

   always_comb begin
      phase_in         = phase_ff;
      length_in        = length_ff;
      count_in         = count_ff;
      push             = 1'b0;
      push_op.op_code  = c8fr_pkg::OP_FUNC;
      push_op.data     = b;
      push_op.position = count_ff;
      if (fire) begin
         case (phase_ff)
            PH_SYNC2: begin
               if (b == sync_second_ff) begin
                  phase_in = PH_FUNC;
               end else if (b == sync_first_ff) begin
                  phase_in = PH_SYNC2;
               end else begin
                  phase_in = PH_HUNT;
               end
            end
            PH_FUNC: begin
               push            = 1'b1;
               push_op.op_code = c8fr_pkg::OP_FUNC;
               phase_in        = PH_LEN;
            end
            PH_LEN: begin
               push            = 1'b1;
               push_op.op_code = c8fr_pkg::OP_LEN;
               length_in       = b;
               count_in        = 8'd0;
               phase_in        = (b == 8'd0) ? PH_CRC : PH_DATA;
            end
            PH_DATA: begin
               push            = 1'b1;
               push_op.op_code = c8fr_pkg::OP_DATA;
               count_in        = count_next;
               if (count_next == length_ff) begin
                  phase_in = PH_CRC;
               end
            end
            PH_CRC: begin
               push            = 1'b1;
               push_op.op_code = c8fr_pkg::OP_CRC;
               count_in        = 8'd0;
               phase_in        = PH_HUNT;
            end
            default: begin
               phase_in = (b == sync_first_ff) ? PH_SYNC2 : PH_HUNT;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_HUNT;
         length_ff      <= 8'd0;
         count_ff       <= 8'd0;
         sync_first_ff  <= c8fr_pkg::SYNC_FIRST_RESET;
         sync_second_ff <= c8fr_pkg::SYNC_SECOND_RESET;
      end else begin
         phase_ff  <= phase_in;
         length_ff <= length_in;
         count_ff  <= count_in;
         if (csr_we && csr_index == c8fr_pkg::CSR_SYNC_FIRST) begin
            sync_first_ff <= csr_wdata;
         end
         if (csr_we && csr_index == c8fr_pkg::CSR_SYNC_SECOND) begin
            sync_second_ff <= csr_wdata;
         end
      end
   end

endmodule

/* sv/c8fr_queue.sv */
// Short first-in first-out queue of classified operations between the two halves.
// Depends on c8fr_pkg and the assertion macro header.
`include "crc8_frame_receiver_macros.svh"

module c8fr_queue #(
   parameter int unsigned DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  c8fr_pkg::op_type push_op,
   output logic             full,
   input  logic             pop,
   output logic             empty,
   output c8fr_pkg::op_type head_op
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

   c8fr_pkg::op_type entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign head_op = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_op;
      end
   end

   `C8FR_ASSERT_ALWAYS(a_no_push_full, !(push && full), "push into a full queue")
   `C8FR_ASSERT_ALWAYS(a_no_pop_empty, !(pop && empty), "pop from an empty queue")
   `C8FR_ASSERT_NEXT(a_count_up, push && !pop, count_ff == $past(count_ff) + 1'b1,
      "occupancy did not rise after a push")
   `C8FR_ASSERT_NEXT(a_head_kept, !empty && !pop, head_op == $past(head_op),
      "head entry changed without a pop")

endmodule

/* sv/c8fr_back.sv */
// Back end: running CRC, held header fields and the registered result stage.
// Depends on c8fr_pkg and c8fr_rsp_if.
module c8fr_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             q_empty,
   input  c8fr_pkg::op_type head_op,
   output logic             pop,
   c8fr_rsp_if.source       rsp_if
);

   logic       rsp_valid_ff, rsp_valid_in;
   logic [1:0] kind_ff;
   logic [7:0] func_out_ff, value_ff, position_ff;
   logic       frame_end_ff;
   logic [7:0] held_func_ff, held_length_ff, crc_ff;
   logic [7:0] crc_step;
   logic       can_load;
   logic       emits;

   assign can_load = !rsp_valid_ff || rsp_if.ready;
   assign pop      = !q_empty && can_load;
   assign emits    = (head_op.op_code == c8fr_pkg::OP_DATA) ||
                     (head_op.op_code == c8fr_pkg::OP_CRC);
   assign crc_step = c8fr_pkg::crc8_update(
                        (head_op.op_code == c8fr_pkg::OP_FUNC) ? c8fr_pkg::CRC_INIT : crc_ff,
                        head_op.data);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (pop && emits) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff   <= 1'b0;
         held_func_ff   <= 8'd0;
         held_length_ff <= 8'd0;
         crc_ff         <= c8fr_pkg::CRC_INIT;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (pop) begin
            case (head_op.op_code)
               c8fr_pkg::OP_FUNC: begin
                  held_func_ff <= head_op.data;
                  crc_ff       <= crc_step;
               end
               c8fr_pkg::OP_LEN: begin
                  held_length_ff <= head_op.data;
                  crc_ff         <= crc_step;
               end
               c8fr_pkg::OP_DATA: begin
                  crc_ff <= crc_step;
               end
               default: begin
                  crc_ff <= c8fr_pkg::CRC_INIT;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop && emits) begin
         func_out_ff <= held_func_ff;
         if (head_op.op_code == c8fr_pkg::OP_DATA) begin
            kind_ff      <= c8fr_pkg::KIND_PAYLOAD;
            value_ff     <= head_op.data;
            position_ff  <= head_op.position;
            frame_end_ff <= 1'b0;
         end else begin
            kind_ff      <= (head_op.data == ~crc_ff) ? c8fr_pkg::KIND_GOOD
                                                      : c8fr_pkg::KIND_MISMATCH;
            value_ff     <= held_length_ff;
            position_ff  <= 8'd0;
            frame_end_ff <= 1'b1;
         end
      end
   end

   assign rsp_if.valid     = rsp_valid_ff;
   assign rsp_if.kind      = kind_ff;
   assign rsp_if.func_code = func_out_ff;
   assign rsp_if.value     = value_ff;
   assign rsp_if.position  = position_ff;
   assign rsp_if.frame_end = frame_end_ff;

endmodule

/* sv/crc8_frame_receiver.sv */
// Top level of the byte-stream frame receiver with CRC-8 check.
// Depends on c8fr_pkg, both channel interfaces, c8fr_front, c8fr_queue and c8fr_back.
//
//   Channel   Direction  Carries
//   req_if    in         one received byte per transaction
//   rsp_if    out        payload byte or frame verdict per transaction
//   csr_*     in         write of sync_first (index 0) or sync_second (index 1)
//
// One byte is accepted per cycle while the operation queue has room.
// Between a byte and its result lie the queue entry and then the output register.
// The queue holds up to QUEUE_DEPTH operations, so bytes keep arriving while the result side
// stalls; sync bytes never enter the queue.
// Synchronous reset returns to sync hunting; no clearing pass is needed.
module crc8_frame_receiver #(
   parameter int unsigned QUEUE_DEPTH = 4
) (
   input  logic                             clock,
   input  logic                             reset,
   c8fr_req_if.sink                         req_if,
   c8fr_rsp_if.source                       rsp_if,
   input  logic                             csr_we,
   input  logic [c8fr_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [7:0]                       csr_wdata
);

   logic             q_full, q_empty, push, pop;
   c8fr_pkg::op_type push_op, head_op;

   c8fr_front u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_if    (req_if),
      .q_full    (q_full),
      .push      (push),
      .push_op   (push_op)
   );

   c8fr_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .push_op (push_op),
      .full    (q_full),
      .pop     (pop),
      .empty   (q_empty),
      .head_op (head_op)
   );

   c8fr_back u_back (
      .clock   (clock),
      .reset   (reset),
      .q_empty (q_empty),
      .head_op (head_op),
      .pop     (pop),
      .rsp_if  (rsp_if)
   );

endmodule

/* dv/crc8_frame_receiver_tb.sv */
// Self-checking testbench for crc8_frame_receiver. It drives received bytes, predicts the
// payload and verdict transactions, and compares them with what the block returns.
// Depends on c8fr_pkg, c8fr_req_if, c8fr_rsp_if and the crc8_frame_receiver RTL.
module crc8_frame_receiver_tb;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] func_code;
      logic [7:0] value;
      logic [7:0] position;
      logic       frame_end;
   } frame_item_type;

   typedef enum logic [2:0] {
      SEEK_SYNC1, SEEK_SYNC2, TAKE_FUNC, TAKE_LEN, TAKE_DATA, CHECK_CRC
   } rx_phase_type;

   typedef enum logic [1:0] {FROM_TABLE, GOOD_CRC, BAD_CRC} byte_src_type;

   typedef struct packed {
      byte_src_type   src;
      logic [7:0]     rx;
      logic           typed;
      logic           some;
      frame_item_type res;
   } table_row_type;

   localparam frame_item_type NO_ITEM = '0;
   localparam int N_ROWS = 24;

   localparam table_row_type DIRECTED_ROWS [N_ROWS] = '{
      '{FROM_TABLE, 8'h00, 1'b1, 1'b0, NO_ITEM},
      '{FROM_TABLE, 8'hAA, 1'b1, 1'b0, NO_ITEM},
      '{FROM_TABLE, 8'hAA, 1'b1, 1'b0, NO_ITEM},
      '{FROM_TABLE, 8'h55, 1'b1, 1'b0, NO_ITEM},
      '{FROM_TABLE, 8'hFF, 1'b1, 1'b0, NO_ITEM},
      '{FROM_TABLE, 8'h00, 1'b1, 1'b0, NO_ITEM},
      '{GOOD_CRC,   8'h00, 1'b1, 1'b1, '{c8fr_pkg::KIND_GOOD, 8'hFF, 8'h00, 8'd0, 1'b1}},
      '{FROM_TABLE, 8'hAA, 1'b1, 1'b0, NO_ITEM},
      '{FROM_TABLE, 8'h13, 1'b1, 1'b0, NO_ITEM},
      '{FROM_TABLE, 8'h55, 1'b1, 1'b0, NO_ITEM},
      '{FROM_TABLE, 8'hAA, 1'b1, 1'b0, NO_ITEM},
      '{FROM_TABLE, 8'h55, 1'b1, 1'b0, NO_ITEM},
      '{FROM_TABLE, 8'h00, 1'b1, 1'b0, NO_ITEM},
      '{FROM_TABLE, 8'h03, 1'b1, 1'b0, NO_ITEM},
      '{FROM_TABLE, 8'h00, 1'b1, 1'b1, '{c8fr_pkg::KIND_PAYLOAD, 8'h00, 8'h00, 8'd0, 1'b0}},
      '{FROM_TABLE, 8'hFF, 1'b1, 1'b1, '{c8fr_pkg::KIND_PAYLOAD, 8'h00, 8'hFF, 8'd1, 1'b0}},
      '{FROM_TABLE, 8'h5A, 1'b0, 1'b0, NO_ITEM},
      '{BAD_CRC,    8'h00, 1'b1, 1'b1, '{c8fr_pkg::KIND_MISMATCH, 8'h00, 8'h03, 8'd0, 1'b1}},
      '{FROM_TABLE, 8'hAA, 1'b1, 1'b0, NO_ITEM},
      '{FROM_TABLE, 8'h55, 1'b1, 1'b0, NO_ITEM},
      '{FROM_TABLE, 8'h80, 1'b1, 1'b0, NO_ITEM},
      '{FROM_TABLE, 8'h01, 1'b1, 1'b0, NO_ITEM},
      '{FROM_TABLE, 8'h01, 1'b0, 1'b0, NO_ITEM},
      '{GOOD_CRC,   8'h00, 1'b0, 1'b0, NO_ITEM}
   };

   logic       clock;
   logic       reset;
   logic       csr_we;
   logic [c8fr_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [7:0] csr_wdata;

   c8fr_req_if req_if ();
   c8fr_rsp_if rsp_if ();

   crc8_frame_receiver u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_if),
      .rsp_if    (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   logic [7:0]   cfg_sync_first = c8fr_pkg::SYNC_FIRST_RESET;
   logic [7:0]   cfg_sync_second = c8fr_pkg::SYNC_SECOND_RESET;
   rx_phase_type rx_phase = SEEK_SYNC1;
   logic [7:0]   cur_func = '0;
   logic [7:0]   cur_len = '0;
   logic [7:0]   payload_idx = '0;
   logic [7:0]   crc_reg = c8fr_pkg::CRC_INIT;

   frame_item_type pending_items[$];
   int fail_count = 0;
   int payload_seen = 0;
   int good_seen = 0;
   int mismatch_seen = 0;
   int bytes_sent = 0;
   int settings_used = 1;
   bit idle_on = 1'b0;
   bit long_hold_req = 1'b0;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #10ms;
      $display("crc8_frame_receiver_tb: errors");
      $finish;
   end

   function automatic logic [7:0] crc8_maxim_step(input logic [7:0] crc, input logic [7:0] d);
      logic [7:0] c;
      logic       fb;
      c = crc;
      for (int i = 0; i < 8; i++) begin
         fb = c[0] ^ d[i];
         c = {1'b0, c[7:1]} ^ (fb ? c8fr_pkg::CRC_POLY_REFL : 8'h00);
      end
      return c;
   endfunction

   function automatic bit predict_rx_byte(input logic [7:0] b, output frame_item_type item);
      bit produced;
      produced = 1'b0;
      item = NO_ITEM;
      case (rx_phase)
         SEEK_SYNC2: begin
            if (b == cfg_sync_second) begin
               rx_phase = TAKE_FUNC;
            end else if (b == cfg_sync_first) begin
               rx_phase = SEEK_SYNC2;
            end else begin
               rx_phase = SEEK_SYNC1;
            end
         end
         TAKE_FUNC: begin
            cur_func = b;
            crc_reg = crc8_maxim_step(c8fr_pkg::CRC_INIT, b);
            rx_phase = TAKE_LEN;
         end
         TAKE_LEN: begin
            cur_len = b;
            crc_reg = crc8_maxim_step(crc_reg, b);
            payload_idx = '0;
            rx_phase = (b == 8'h00) ? CHECK_CRC : TAKE_DATA;
         end
         TAKE_DATA: begin
            crc_reg = crc8_maxim_step(crc_reg, b);
            item = '{c8fr_pkg::KIND_PAYLOAD, cur_func, b, payload_idx, 1'b0};
            produced = 1'b1;
            payload_idx = payload_idx + 8'd1;
            if (payload_idx == cur_len) begin
               rx_phase = CHECK_CRC;
            end
         end
         CHECK_CRC: begin
            item = '{(b == ~crc_reg) ? c8fr_pkg::KIND_GOOD : c8fr_pkg::KIND_MISMATCH,
                     cur_func, cur_len, 8'd0, 1'b1};
            produced = 1'b1;
            rx_phase = SEEK_SYNC1;
            crc_reg = c8fr_pkg::CRC_INIT;
            payload_idx = '0;
         end
         default: begin
            rx_phase = (b == cfg_sync_first) ? SEEK_SYNC2 : SEEK_SYNC1;
         end
      endcase
      return produced;
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return $urandom_range(1, 2);
      if (r < 94) return $urandom_range(3, 6);
      return $urandom_range(12, 40);
   endfunction

   task automatic report_error(input string what, input frame_item_type want,
                               input frame_item_type got);
      fail_count++;
      if (fail_count <= 10) begin
         $display("%0t ns %s: expected kind %0d func %h value %h pos %0d end %0b", $realtime,
                  what, want.kind, want.func_code, want.value, want.position, want.frame_end);
         $display("   got kind %0d func %h value %h pos %0d end %0b",
                  got.kind, got.func_code, got.value, got.position, got.frame_end);
      end
   endtask

   task automatic check_frame_item();
      frame_item_type got;
      frame_item_type want;
      got = '{rsp_if.kind, rsp_if.func_code, rsp_if.value, rsp_if.position, rsp_if.frame_end};
      if (pending_items.size() == 0) begin
         report_error("transaction with nothing pending", NO_ITEM, got);
      end else begin
         want = pending_items.pop_front();
         if (got !== want) begin
            report_error("transaction mismatch", want, got);
         end
         case (want.kind)
            c8fr_pkg::KIND_PAYLOAD: payload_seen++;
            c8fr_pkg::KIND_GOOD:    good_seen++;
            default:                mismatch_seen++;
         endcase
      end
   endtask

   task automatic push_byte(input logic [7:0] b, input bit typed, input bit typed_some,
                            input frame_item_type typed_item);
      frame_item_type item;
      bit produced;
      if (idle_on && $urandom_range(0, 2) == 0) begin
         req_if.valid <= 1'b0;
         repeat (pick_gap()) @(posedge clock);
      end
      req_if.valid   <= 1'b1;
      req_if.rx_byte <= b;
      do @(posedge clock); while (!req_if.ready);
      bytes_sent++;
      produced = predict_rx_byte(b, item);
      if (typed) begin
         produced = typed_some;
         item = typed_item;
      end
      if (produced) pending_items = {pending_items, item};
   endtask

   task automatic send_frame(input int len, input bit bad_crc, input int cut_at);
      logic [7:0] frame_bytes[$];
      logic [7:0] crc;
      logic [7:0] d;
      frame_bytes = {cfg_sync_first};
      if ($urandom_range(0, 9) == 0) frame_bytes = {frame_bytes, cfg_sync_first};
      frame_bytes = {frame_bytes, cfg_sync_second};
      d = 8'($urandom_range(0, 255));
      crc = crc8_maxim_step(c8fr_pkg::CRC_INIT, d);
      frame_bytes = {frame_bytes, d};
      d = len[7:0];
      crc = crc8_maxim_step(crc, d);
      frame_bytes = {frame_bytes, d};
      for (int i = 0; i < len; i++) begin
         d = 8'($urandom_range(0, 255));
         crc = crc8_maxim_step(crc, d);
         frame_bytes = {frame_bytes, d};
      end
      crc = ~crc;
      if (bad_crc) crc = crc ^ (8'h01 << $urandom_range(0, 7));
      frame_bytes = {frame_bytes, crc};
      for (int i = 0; i < frame_bytes.size() && (cut_at < 0 || i < cut_at); i++) begin
         push_byte(frame_bytes[i], 1'b0, 1'b0, NO_ITEM);
      end
   endtask

   task automatic random_traffic(input int budget);
      int sent;
      int r;
      int len;
      sent = 0;
      while (sent < budget) begin
         idle_on = ($urandom_range(0, 4) != 0);
         r = $urandom_range(0, 99);
         if (r < 10) begin
            repeat ($urandom_range(1, 4)) begin
               push_byte(8'($urandom_range(0, 255)), 1'b0, 1'b0, NO_ITEM);
            end
         end else begin
            len = (r < 22) ? 0 : $urandom_range(1, 9);
            send_frame(len, r >= 80, (r >= 92) ? $urandom_range(1, len + 4) : -1);
            sent += len + 5;
         end
      end
   endtask

   task automatic write_syncs(input logic [7:0] first, input logic [7:0] second);
      req_if.valid <= 1'b0;
      while (pending_items.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= c8fr_pkg::CSR_SYNC_FIRST;
      csr_wdata <= first;
      @(posedge clock);
      cfg_sync_first = first;
      csr_index <= c8fr_pkg::CSR_SYNC_SECOND;
      csr_wdata <= second;
      @(posedge clock);
      cfg_sync_second = second;
      csr_we <= 1'b0;
      settings_used++;
   endtask

   initial begin : result_sink
      int hold_cycles;
      hold_cycles = 0;
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_if.valid && rsp_if.ready) check_frame_item();
         if (long_hold_req) begin
            long_hold_req = 1'b0;
            hold_cycles = 80;
         end
         if (hold_cycles > 0) begin
            hold_cycles--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= 1'b1;
            if (idle_on && $urandom_range(0, 3) == 0) hold_cycles = pick_gap();
         end
      end
   end

   initial begin : stimulus
      logic [7:0] b;
      int wait_cycles;
      reset          <= 1'b1;
      csr_we         <= 1'b0;
      csr_index      <= c8fr_pkg::CSR_SYNC_FIRST;
      csr_wdata      <= 8'h00;
      req_if.valid   <= 1'b0;
      req_if.rx_byte <= 8'h00;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      idle_on = 1'b1;
      for (int i = 0; i < N_ROWS; i++) begin
         case (DIRECTED_ROWS[i].src)
            GOOD_CRC: b = ~crc_reg;
            BAD_CRC:  b = ~crc_reg ^ 8'h01;
            default:  b = DIRECTED_ROWS[i].rx;
         endcase
         push_byte(b, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].some, DIRECTED_ROWS[i].res);
      end
      random_traffic(30);

      write_syncs(8'h00, 8'hFF);
      idle_on = 1'b0;
      long_hold_req = 1'b1;
      send_frame(12, 1'b0, -1);
      send_frame(12, 1'b1, -1);
      random_traffic(40);
      idle_on = 1'b1;
      send_frame(255, 1'b0, -1);

      write_syncs(8'hFF, 8'h00);
      random_traffic(30);
      write_syncs(8'h3C, 8'h3C);
      random_traffic(30);
      write_syncs(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      random_traffic(30);
      write_syncs(c8fr_pkg::SYNC_FIRST_RESET, c8fr_pkg::SYNC_SECOND_RESET);
      random_traffic(20);

      req_if.valid <= 1'b0;
      wait_cycles = 0;
      while (pending_items.size() != 0 && wait_cycles < 20000) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (10) @(posedge clock);
      if (pending_items.size() != 0) begin
         $display("%0d expected transactions never arrived", pending_items.size());
         fail_count += pending_items.size();
      end

      $display("Sent %0d bytes under %0d sync settings, with a maximum-length frame and a long",
               bytes_sent, settings_used);
      $display("result stall; checked %0d payload bytes, %0d good and %0d mismatched frames.",
               payload_seen, good_seen, mismatch_seen);
      if (fail_count == 0) begin
         $display("crc8_frame_receiver_tb: clean");
      end else begin
         $display("crc8_frame_receiver_tb: errors");
      end
      $finish;
   end

endmodule
